@@ rtl/acr_pkg.sv @@
// Package for the ARP cache and responder: word types, command and result
// codes, protocol constants and the sequencer state type.
// No dependencies; used by acr_if, arp_cache_responder_top and acr_checker.
package acr_pkg;

  localparam int unsigned DEF_ENTRIES = 16;

  localparam int unsigned MAC_W = 48;
  localparam int unsigned IP_W  = 32;

  // command codes of an input word
  localparam logic [1:0] CMD_RX     = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_SEND   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_HIT     = 2'd0;
  localparam logic [1:0] KIND_MISS    = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;
  localparam logic [1:0] KIND_REQUEST = 2'd3;

  // configuration register indexes
  localparam logic CFG_OWN_MAC = 1'b0;
  localparam logic CFG_OWN_IP  = 1'b1;

  localparam logic [15:0] OP_REQUEST  = 16'd1;
  localparam logic [15:0] OP_REPLY    = 16'd2;
  localparam logic [15:0] ARP_MIN_LEN = 16'd28;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;

  localparam logic [MAC_W-1:0] MAC_BCAST = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [15:0]      pkt_len;
    logic [15:0]      proto_type;
    logic [15:0]      opcode_in;
    logic [MAC_W-1:0] sender_mac_in;
    logic [IP_W-1:0]  sender_ip_in;
    logic [IP_W-1:0]  target_ip_in;
    logic [IP_W-1:0]  query_ip;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [MAC_W-1:0] found_mac;
    logic [MAC_W-1:0] dest_mac;
    logic [15:0]      opcode_out;
    logic [MAC_W-1:0] sender_mac_out;
    logic [IP_W-1:0]  sender_ip_out;
    logic [MAC_W-1:0] target_mac_out;
    logic [IP_W-1:0]  target_ip_out;
  } out_word_t;

endpackage

@@ rtl/acr_if.sv @@
// Valid/ready channel interfaces for the ARP cache and responder.
// Depends on acr_pkg for the word types.
interface acr_in_if;
  logic              valid;
  logic              ready;
  acr_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acr_out_if;
  logic               valid;
  logic               ready;
  acr_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/arp_cache_responder_top.sv @@
// ARP cache and responder, top level. Depends on acr_pkg, acr_if, acr_ram.
// A received packet or a lookup scans the cache one entry per cycle through the RAM read port
// and the single IP comparator, and a received packet then takes a write-back step when
// learning; send-request words and dropped or unknown words skip the scan. One word at a
// time: ready rises with the result word, or later while an earlier result is stalled.
// Reset clears the valid bits and own MAC/IP.
module arp_cache_responder_top #(
  parameter int unsigned ENTRIES = acr_pkg::DEF_ENTRIES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  acr_in_if.sink                   in_i,
  acr_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [acr_pkg::MAC_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(ENTRIES - 1);
  localparam int unsigned MAC_W = acr_pkg::MAC_W;
  localparam int unsigned IP_W  = acr_pkg::IP_W;

  acr_pkg::state_e state_q, state_d;

  logic [MAC_W-1:0] own_mac_q;
  logic [IP_W-1:0]  own_ip_q;

  acr_pkg::in_word_t  item_q, item_d;
  acr_pkg::out_word_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               issue_done_q, issue_done_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic               slot_ok_q, slot_ok_d;
  logic               hit_q, hit_d;
  logic [MAC_W-1:0]   mac_q, mac_d;
  logic               res_q, res_d;
  logic [IP_W-1:0]    key_q, key_d;

  logic                  ram_we;
  logic [IP_W+MAC_W-1:0] ram_rdata;
  logic [IP_W-1:0]       rd_ip;
  logic [MAC_W-1:0]      rd_mac;
  logic                  ip_eq;
  logic                  entry_vld;
  logic                  pkt_ok;

  assign rd_ip     = ram_rdata[IP_W+MAC_W-1:MAC_W];
  assign rd_mac    = ram_rdata[MAC_W-1:0];
  // the one shared comparator of the scan
  assign ip_eq     = (rd_ip == key_q);
  assign entry_vld = valid_q[cmp_idx_q];
  assign pkt_ok    = (in_i.data.pkt_len >= acr_pkg::ARP_MIN_LEN) &&
                     (in_i.data.proto_type == acr_pkg::PROTO_IPV4);

  assign ram_we = (state_q == acr_pkg::ST_WRITE) && slot_ok_q;

  acr_ram #(
    .WIDTH (IP_W + MAC_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i ({item_q.sender_ip_in, item_q.sender_mac_in}),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready  = (state_q == acr_pkg::ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        acr_pkg::CFG_OWN_MAC: own_mac_q <= cfg_data_i;
        acr_pkg::CFG_OWN_IP:  own_ip_q  <= cfg_data_i[IP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= acr_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      valid_q      <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      valid_q      <= valid_d;
      issue_done_q <= issue_done_d;
      cmp_vld_q    <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    out_q     <= out_d;
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    slot_ok_q <= slot_ok_d;
    hit_q     <= hit_d;
    mac_q     <= mac_d;
    res_q     <= res_d;
    key_q     <= key_d;
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    valid_d      = valid_q;
    idx_d        = idx_q;
    issue_done_d = issue_done_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = idx_q;
    slot_d       = slot_q;
    slot_ok_d    = slot_ok_q;
    hit_d        = hit_q;
    mac_d        = mac_q;
    res_d        = res_q;
    key_d        = key_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      acr_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          item_d       = in_i.data;
          idx_d        = '0;
          issue_done_d = 1'b0;
          slot_ok_d    = 1'b0;
          hit_d        = 1'b0;
          key_d        = (in_i.data.command == acr_pkg::CMD_RX) ?
                         in_i.data.sender_ip_in : in_i.data.query_ip;
          res_d        = 1'b0;
          state_d      = acr_pkg::ST_OUT;
          case (in_i.data.command)
            acr_pkg::CMD_RX: begin
              if (pkt_ok) begin
                res_d   = (in_i.data.opcode_in == acr_pkg::OP_REQUEST) &&
                          (in_i.data.target_ip_in == own_ip_q);
                state_d = acr_pkg::ST_SCAN;
              end
            end
            acr_pkg::CMD_LOOKUP: begin
              res_d   = 1'b1;
              state_d = acr_pkg::ST_SCAN;
            end
            acr_pkg::CMD_SEND: begin
              res_d = 1'b1;
            end
            default: ;
          endcase
        end
      end

      acr_pkg::ST_SCAN: begin
        // read address runs one entry ahead of the compare
        cmp_vld_d = !issue_done_q;
        if (!issue_done_q) begin
          if (idx_q == LastIdx) begin
            issue_done_d = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (cmp_vld_q) begin
          if (entry_vld && ip_eq) begin
            hit_d     = 1'b1;
            slot_d    = cmp_idx_q;
            slot_ok_d = 1'b1;
            mac_d     = rd_mac;
          end else if (!entry_vld && !slot_ok_q) begin
            slot_d    = cmp_idx_q;
            slot_ok_d = 1'b1;
          end
          if ((entry_vld && ip_eq) || (cmp_idx_q == LastIdx)) begin
            cmp_vld_d = 1'b0;
            state_d   = (item_q.command == acr_pkg::CMD_RX) ?
                        acr_pkg::ST_WRITE : acr_pkg::ST_OUT;
          end
        end
      end

      acr_pkg::ST_WRITE: begin
        if (slot_ok_q) begin
          valid_d[slot_q] = 1'b1;
        end
        state_d = acr_pkg::ST_OUT;
      end

      acr_pkg::ST_OUT: begin
        if (!res_q) begin
          state_d = acr_pkg::ST_IDLE;
        end else if (!out_valid_q || out_o.ready) begin
          out_d       = '0;
          out_valid_d = 1'b1;
          state_d     = acr_pkg::ST_IDLE;
          case (item_q.command)
            acr_pkg::CMD_RX: begin
              out_d.result_kind    = acr_pkg::KIND_REPLY;
              out_d.dest_mac       = item_q.sender_mac_in;
              out_d.opcode_out     = acr_pkg::OP_REPLY;
              out_d.sender_mac_out = own_mac_q;
              out_d.sender_ip_out  = item_q.target_ip_in;
              out_d.target_mac_out = item_q.sender_mac_in;
              out_d.target_ip_out  = item_q.sender_ip_in;
            end
            acr_pkg::CMD_LOOKUP: begin
              out_d.result_kind = hit_q ? acr_pkg::KIND_HIT : acr_pkg::KIND_MISS;
              out_d.found_mac   = hit_q ? mac_q : '0;
            end
            acr_pkg::CMD_SEND: begin
              out_d.result_kind    = acr_pkg::KIND_REQUEST;
              out_d.dest_mac       = acr_pkg::MAC_BCAST;
              out_d.opcode_out     = acr_pkg::OP_REQUEST;
              out_d.sender_mac_out = own_mac_q;
              out_d.sender_ip_out  = own_ip_q;
              out_d.target_ip_out  = item_q.query_ip;
            end
            default: begin
              out_valid_d = out_valid_q && !out_o.ready;
            end
          endcase
        end
      end

      default: begin
        state_d = acr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/acr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/acr_checker.sv @@
// Port-level checks for the ARP cache and responder, bound to the top level.
// Depends on acr_pkg and arp_cache_responder_top.
module acr_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input acr_pkg::out_word_t       out_data
);

  // one word in flight: no acceptance in the cycle right after one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken on consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word changed or dropped");

  a_reply_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_data.result_kind == acr_pkg::KIND_REPLY) |->
      (out_data.opcode_out == acr_pkg::OP_REPLY &&
       out_data.dest_mac == out_data.target_mac_out &&
       out_data.found_mac == '0))
    else $error("malformed reply word");

  a_request_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_data.result_kind == acr_pkg::KIND_REQUEST) |->
      (out_data.opcode_out == acr_pkg::OP_REQUEST &&
       out_data.dest_mac == acr_pkg::MAC_BCAST &&
       out_data.target_mac_out == '0))
    else $error("malformed request word");

  a_lookup_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (out_data.result_kind == acr_pkg::KIND_HIT ||
                   out_data.result_kind == acr_pkg::KIND_MISS)) |->
      (out_data.opcode_out == '0 && out_data.dest_mac == '0 &&
       out_data.sender_ip_out == '0))
    else $error("lookup word carries frame fields");

endmodule

bind arp_cache_responder_top acr_checker u_acr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);
